/* rtl/ppss_pkg.sv */
// Shared types, constants and the arctangent table for the pure pursuit block.
// No dependencies.
package ppss_pkg;

    localparam int CORDIC_ITERS    = 28;
    localparam int VEC_LAT         = CORDIC_ITERS + 1;
    localparam int DIV_QBITS       = 9;
    localparam int DIV_NUM_W       = 24;
    localparam int DIV_DEN_W       = 14;
    localparam int ANG_W           = 32;
    localparam int ROT_W           = 34;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int PIPE_LAT        = 3 * VEC_LAT + 6 + DIV_QBITS;
    localparam logic signed [ROT_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;
    localparam logic signed [15:0] STEER_PER_PI = 16'sd12780;

    localparam logic [15:0] WHEEL_BASE_RST = 16'd1040;
    localparam logic [15:0] LOOKAHEAD_RST  = 16'd7000;
    localparam logic [15:0] SPEED_SCALE_RST = 16'd32768;
    localparam logic [12:0] STEER_LIMIT_RST = 13'd2000;
    localparam logic [7:0]  MAX_SPEED_RST  = 8'd50;
    localparam logic [7:0]  MIN_SPEED_RST  = 8'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHEEL_BASE  = 3'd0,
        CFG_LOOKAHEAD   = 3'd1,
        CFG_SPEED_SCALE = 3'd2,
        CFG_STEER_LIMIT = 3'd3,
        CFG_MAX_SPEED   = 3'd4,
        CFG_MIN_SPEED   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] yaw;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
    } item_t;

    typedef struct packed {
        logic signed [13:0] steer_cmd;
        logic        [8:0]  speed_cmd;
        logic               steer_clamped;
    } result_t;

    function automatic logic [31:0] atan_val(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10680862;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/ppss_vec_cordic.sv */
// Pipelined vectoring CORDIC, one iteration per stage; returns atan2(y, x)
// as a binary angle (pi = 2^31). Depends on ppss_pkg.
module ppss_vec_cordic
    import ppss_pkg::*;
#(
    parameter int W = 64
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    output logic                 out_valid,
    output logic [ANG_W-1:0]     angle
);

    logic                 v_reg    [0:CORDIC_ITERS];
    logic                 zero_reg [0:CORDIC_ITERS];
    logic signed [W-1:0]  x_reg    [0:CORDIC_ITERS];
    logic signed [W-1:0]  y_reg    [0:CORDIC_ITERS];
    logic signed [ROT_W-1:0] z_reg [0:CORDIC_ITERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (x_in == '0) && (y_in == '0);
        if (x_in < 0)
        begin
            x_reg[0] <= -x_in;
            y_reg[0] <= -y_in;
            z_reg[0] <= 34'sd2147483648;
        end
        else
        begin
            x_reg[0] <= x_in;
            y_reg[0] <= y_in;
            z_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_iter
        localparam logic signed [ROT_W-1:0] ATAN_I = {2'b00, atan_val(i)};
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (y_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                z_reg[i+1] <= z_reg[i] + ATAN_I;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                z_reg[i+1] <= z_reg[i] - ATAN_I;
            end
        end
    end

    assign out_valid = v_reg[CORDIC_ITERS];
    assign angle     = zero_reg[CORDIC_ITERS] ? '0 : z_reg[CORDIC_ITERS][ANG_W-1:0];

endmodule

/* rtl/ppss_rot_cordic.sv */
// Pipelined rotation CORDIC giving sin(a) in Q30, with a fold by pi for
// angles beyond a right angle. Depends on ppss_pkg.
module ppss_rot_cordic
    import ppss_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [ANG_W-1:0] ang,
    output logic                    out_valid,
    output logic signed [ROT_W-1:0] sin_out
);

    localparam logic signed [ROT_W-1:0] HALF_PI = 34'sd1073741824;
    localparam logic signed [ROT_W-1:0] PI_ANG  = 34'sd2147483648;

    logic                    v_reg   [0:CORDIC_ITERS];
    logic                    neg_reg [0:CORDIC_ITERS];
    logic signed [ROT_W-1:0] x_reg   [0:CORDIC_ITERS];
    logic signed [ROT_W-1:0] y_reg   [0:CORDIC_ITERS];
    logic signed [ROT_W-1:0] z_reg   [0:CORDIC_ITERS];
    logic signed [ROT_W-1:0] a_ext;

    assign a_ext = ROT_W'(ang);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= CORDIC_INV_GAIN;
        y_reg[0] <= '0;
        if (a_ext > HALF_PI)
        begin
            z_reg[0]   <= a_ext - PI_ANG;
            neg_reg[0] <= 1'b1;
        end
        else if (a_ext < -HALF_PI)
        begin
            z_reg[0]   <= a_ext + PI_ANG;
            neg_reg[0] <= 1'b1;
        end
        else
        begin
            z_reg[0]   <= a_ext;
            neg_reg[0] <= 1'b0;
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_iter
        localparam logic signed [ROT_W-1:0] ATAN_I = {2'b00, atan_val(i)};
        logic signed [ROT_W-1:0] xs;
        logic signed [ROT_W-1:0] ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            neg_reg[i+1] <= neg_reg[i];
            if (z_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                z_reg[i+1] <= z_reg[i] - ATAN_I;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                z_reg[i+1] <= z_reg[i] + ATAN_I;
            end
        end
    end

    assign out_valid = v_reg[CORDIC_ITERS];
    assign sin_out   = neg_reg[CORDIC_ITERS] ? -y_reg[CORDIC_ITERS] : y_reg[CORDIC_ITERS];

endmodule

/* rtl/ppss_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on ppss_pkg.
module ppss_div
    import ppss_pkg::*;
#(
    parameter int SW = 1
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    input  logic [SW-1:0]        in_side,
    output logic                 out_valid,
    output logic [DIV_QBITS-1:0] quo,
    output logic [SW-1:0]        out_side
);

    logic                 v_reg    [0:DIV_QBITS];
    logic [DIV_NUM_W-1:0] rem_reg  [0:DIV_QBITS];
    logic [DIV_DEN_W-1:0] den_reg  [0:DIV_QBITS];
    logic [DIV_QBITS-1:0] q_reg    [0:DIV_QBITS];
    logic [SW-1:0]        side_reg [0:DIV_QBITS];

    always_comb
    begin
        v_reg[0]    = in_valid;
        rem_reg[0]  = num;
        den_reg[0]  = den;
        q_reg[0]    = '0;
        side_reg[0] = in_side;
    end

    for (genvar k = 0; k < DIV_QBITS; k++)
    begin : g_step
        localparam int SH = DIV_QBITS - 1 - k;
        logic [DIV_NUM_W-1:0] trial;
        logic                 fits;

        assign trial = DIV_NUM_W'(den_reg[k]) << SH;
        assign fits  = rem_reg[k] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= fits ? rem_reg[k] - trial : rem_reg[k];
            q_reg[k+1]    <= {q_reg[k][DIV_QBITS-2:0], fits};
            den_reg[k+1]  <= den_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = v_reg[DIV_QBITS];
    assign quo       = q_reg[DIV_QBITS];
    assign out_side  = side_reg[DIV_QBITS];

endmodule

/* rtl/pure_pursuit_steer_speed_top.sv */
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Depth is set by three 29-stage CORDIC pipelines and a 9-stage divider.
// Reset clears valid bits and restores the configuration registers.
// The receiver cannot stall: each result is shown for one cycle only.
module pure_pursuit_steer_speed_top
    import ppss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  item_t                 item,
    output logic                  done,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int VEC1_W = 64;
    localparam int VEC2_W = 52;
    localparam int SIDE_W = 17;

    logic [15:0] wb_reg;
    logic [15:0] look_reg;
    logic [15:0] scale_reg;
    logic [12:0] lim_reg;
    logic [7:0]  max_reg;
    logic [7:0]  min_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg    <= WHEEL_BASE_RST;
            look_reg  <= LOOKAHEAD_RST;
            scale_reg <= SPEED_SCALE_RST;
            lim_reg   <= STEER_LIMIT_RST;
            max_reg   <= MAX_SPEED_RST;
            min_reg   <= MIN_SPEED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WHEEL_BASE:  wb_reg    <= cfg_data;
                CFG_LOOKAHEAD:   look_reg  <= cfg_data;
                CFG_SPEED_SCALE: scale_reg <= cfg_data;
                CFG_STEER_LIMIT: lim_reg   <= cfg_data[12:0];
                CFG_MAX_SPEED:   max_reg   <= cfg_data[7:0];
                CFG_MIN_SPEED:   min_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // bearing
    logic                     acc;
    logic signed [32:0]       dx;
    logic signed [32:0]       dy;
    logic signed [VEC1_W-1:0] x1;
    logic signed [VEC1_W-1:0] y1;
    logic                     th_valid;
    logic [ANG_W-1:0]         theta;
    logic signed [15:0]       yaw_reg [0:VEC_LAT-1];

    assign acc = start && !busy;
    assign dx  = {item.pos_x[31], item.pos_x} - {item.target_x[31], item.target_x};
    assign dy  = {item.pos_y[31], item.pos_y} - {item.target_y[31], item.target_y};
    assign x1  = {{3{dx[32]}}, dx, 28'b0};
    assign y1  = {{3{dy[32]}}, dy, 28'b0};

    ppss_vec_cordic #(.W(VEC1_W)) u_bearing (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc),
        .x_in      (x1),
        .y_in      (y1),
        .out_valid (th_valid),
        .angle     (theta)
    );

    always_ff @(posedge clk)
    begin
        yaw_reg[0] <= item.yaw;
        for (int k = 1; k < VEC_LAT; k++)
        begin
            yaw_reg[k] <= yaw_reg[k-1];
        end
    end

    // sin(alpha)
    logic signed [ANG_W-1:0] alpha;
    logic                    sin_valid;
    logic signed [ROT_W-1:0] sin_a;

    assign alpha = signed'({yaw_reg[VEC_LAT-1], 16'b0} - theta);

    ppss_rot_cordic u_sin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (th_valid),
        .ang       (alpha),
        .out_valid (sin_valid),
        .sin_out   (sin_a)
    );

    // Y = 2 * wheel base * sin
    logic                     yy_v_reg;
    logic signed [VEC2_W-1:0] yy_reg;
    logic signed [VEC2_W-1:0] yy_next;
    logic signed [VEC2_W-1:0] xx;

    assign yy_next = VEC2_W'($signed({1'b0, wb_reg, 1'b0}) * sin_a);
    assign xx      = {6'b0, look_reg, 30'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yy_v_reg <= 1'b0;
        end
        else
        begin
            yy_v_reg <= sin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        yy_reg <= yy_next;
    end

    logic             phi_valid;
    logic [ANG_W-1:0] phi;

    ppss_vec_cordic #(.W(VEC2_W)) u_steer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (yy_v_reg),
        .x_in      (xx),
        .y_in      (yy_reg),
        .out_valid (phi_valid),
        .angle     (phi)
    );

    // conversion to steer units
    logic               n_v_reg;
    logic signed [47:0] n_reg;
    logic signed [47:0] n_next;

    assign n_next = 48'($signed(phi) * STEER_PER_PI) + (48'sd1 <<< 30);

    // rounding toward zero, clamp
    logic signed [47:0] n_abs;
    logic signed [16:0] raw;
    logic signed [16:0] lim_s;
    logic               st_v_reg;
    logic signed [13:0] steer_reg;
    logic signed [13:0] steer_next;
    logic               clamp_reg;
    logic               clamp_next;
    logic [12:0]        mag_reg;
    logic [12:0]        mag_next;

    assign n_abs = (n_reg < 0) ? -n_reg : n_reg;
    assign raw   = (n_reg < 0) ? -17'(n_abs >>> 31) : 17'(n_abs >>> 31);
    assign lim_s = {4'b0, lim_reg};

    always_comb
    begin
        steer_next = 14'(raw);
        clamp_next = 1'b0;
        if (raw >= lim_s)
        begin
            steer_next = 14'(lim_s);
            clamp_next = 1'b1;
        end
        else if (raw <= -lim_s)
        begin
            steer_next = 14'(-lim_s);
            clamp_next = 1'b1;
        end
        mag_next = (steer_next < 0) ? 13'(-steer_next) : 13'(steer_next);
    end

    // blend product
    logic signed [8:0]  diff;
    logic               q_v_reg;
    logic signed [22:0] q_reg;
    logic signed [13:0] steer_q_reg;
    logic               clamp_q_reg;

    assign diff = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});

    // divider operands
    logic signed [24:0]    num_s;
    logic                  d_v_reg;
    logic [DIV_NUM_W-1:0]  num_reg;
    logic [SIDE_W-1:0]     side_reg;

    assign num_s = {q_reg[22], q_reg, 1'b0} + 25'($signed({1'b0, lim_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_v_reg  <= 1'b0;
            st_v_reg <= 1'b0;
            q_v_reg  <= 1'b0;
            d_v_reg  <= 1'b0;
        end
        else
        begin
            n_v_reg  <= phi_valid;
            st_v_reg <= n_v_reg;
            q_v_reg  <= st_v_reg;
            d_v_reg  <= q_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        steer_reg   <= steer_next;
        clamp_reg   <= clamp_next;
        mag_reg     <= mag_next;
        q_reg       <= 23'($signed({1'b0, lim_reg - mag_reg}) * diff);
        steer_q_reg <= steer_reg;
        clamp_q_reg <= clamp_reg;
        num_reg     <= (num_s < 0) ? DIV_NUM_W'(-num_s) : DIV_NUM_W'(num_s);
        side_reg    <= {steer_q_reg, clamp_q_reg, num_s < 0, lim_reg == '0};
    end

    logic                 dv_valid;
    logic [DIV_QBITS-1:0] quo;
    logic [SIDE_W-1:0]    side_o;

    ppss_div #(.SW(SIDE_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_v_reg),
        .num       (num_reg),
        .den       ({lim_reg, 1'b0}),
        .in_side   (side_reg),
        .out_valid (dv_valid),
        .quo       (quo),
        .out_side  (side_o)
    );

    // speed and output register
    logic signed [10:0] term;
    logic signed [10:0] base;
    logic [27:0]        spd_full;
    logic               done_reg;
    result_t            result_reg;
    result_t            result_next;

    always_comb
    begin
        if (side_o[0])
        begin
            term = 11'(diff);
        end
        else if (side_o[1])
        begin
            term = -$signed({2'b0, quo});
        end
        else
        begin
            term = $signed({2'b0, quo});
        end
        base     = $signed({3'b0, min_reg}) + term;
        spd_full = 28'({base[9:0], 1'b0}) * 28'(scale_reg) + 28'd32768;
        result_next.steer_cmd     = side_o[SIDE_W-1:3];
        result_next.steer_clamped = side_o[2];
        result_next.speed_cmd     = spd_full[24:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##PIPE_LAT done)
        else $error("accepted item did not complete on time");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(dv_valid))
        else $error("done without a divider result");

    a_unclamped: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.steer_clamped |->
            (result.steer_cmd < $signed({1'b0, lim_reg}))
            && (result.steer_cmd > -$signed({1'b0, lim_reg})))
        else $error("unclamped steer outside limit");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.steer_clamped |->
            (result.steer_cmd == $signed({1'b0, lim_reg}))
            || (result.steer_cmd == -$signed({1'b0, lim_reg})))
        else $error("clamped steer not at limit");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for pure_pursuit_steer_speed_top: bit-exact CORDIC steering
// and speed predictor, bursty command driver, strobe monitor, register phases.
// Depends on ppss_pkg and the RTL top level.
module tb_top
    import ppss_pkg::*;
();

    localparam int LAT_WAIT = 120;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  done;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pure_pursuit_steer_speed_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of the registers
    logic [15:0] m_wheel_base;
    logic [15:0] m_lookahead;
    logic [15:0] m_scale;
    logic [12:0] m_limit;
    logic [7:0]  m_max;
    logic [7:0]  m_min;

    item_t   pending_items[$];
    result_t expected_cmds[$];
    int      mismatches;
    int      idle_cycles;
    int      burst_left;
    int      gap_left;
    bit      steady_mode;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint atan_entry(int i);
        return longint'(atan_val(i));
    endfunction

    // vectoring CORDIC, binary angle with pi = 2^31
    function automatic longint cordic_atan2(longint y, longint x);
        longint base;
        longint z;
        longint xs;
        longint ys;
        base = 0;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            base = longint'(1) << 31;
        end
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; z += atan_entry(i);
            end
            else
            begin
                x -= ys; y += xs; z -= atan_entry(i);
            end
        end
        return base + z;
    endfunction

    // rotation CORDIC, sine in Q30, folded beyond +-pi/2
    function automatic longint cordic_sin(longint a);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit     neg;
        x = 652032874;
        y = 0;
        z = a;
        neg = 1'b0;
        if (z > (longint'(1) << 30))
        begin
            z -= longint'(1) << 31;
            neg = 1'b1;
        end
        else if (z < -(longint'(1) << 30))
        begin
            z += longint'(1) << 31;
            neg = 1'b1;
        end
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_entry(i);
            end
            else
            begin
                x += ys; y -= xs; z += atan_entry(i);
            end
        end
        return neg ? -y : y;
    endfunction

    function automatic result_t steer_speed(item_t it);
        result_t     r;
        logic [31:0] theta;
        logic [31:0] alpha_u;
        longint      alpha;
        longint      s;
        longint      phi;
        longint      raw;
        longint      lim;
        longint      steer;
        longint      mag;
        longint      term;
        longint      base;
        longint      spd;
        longint      q;
        bit          clamped;
        theta = 32'(cordic_atan2((longint'(it.pos_y) - longint'(it.target_y)) <<< 28,
                                 (longint'(it.pos_x) - longint'(it.target_x)) <<< 28));
        alpha_u = {it.yaw, 16'h0000} - theta;
        alpha = longint'(signed'(alpha_u));
        s = cordic_sin(alpha);
        phi = cordic_atan2(2 * longint'(m_wheel_base) * s, longint'(m_lookahead) <<< 30);
        raw = (12780 * phi + (longint'(1) << 30)) / (longint'(1) << 31);
        lim = longint'(m_limit);
        steer = raw;
        clamped = 1'b0;
        if (raw >= lim)
        begin
            steer = lim;
            clamped = 1'b1;
        end
        else if (raw <= -lim)
        begin
            steer = -lim;
            clamped = 1'b1;
        end
        mag = steer < 0 ? -steer : steer;
        if (lim == 0)
            term = longint'(m_max) - longint'(m_min);
        else
        begin
            q = (lim - mag) * (longint'(m_max) - longint'(m_min));
            term = (2 * q + lim) / (2 * lim);
        end
        base = longint'(m_min) + term;
        spd = (2 * base * longint'(m_scale) + 32768) >>> 16;
        r.steer_cmd = steer[13:0];
        r.speed_cmd = spd[8:0];
        r.steer_clamped = clamped;
        return r;
    endfunction

    // driver: bursts of random length, random gaps
    always @(negedge clk)
    begin
        if (!rst_n || pending_items.size() == 0 || gap_left > 0)
        begin
            start <= 1'b0;
            if (gap_left > 0)
                gap_left <= gap_left - 1;
        end
        else
        begin
            start <= 1'b1;
            item <= pending_items[0];
        end
    end

    // accepted command transfers feed the expectation queue
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            expected_cmds.push_back(steer_speed(item));
            void'(pending_items.pop_front());
            if (!steady_mode)
            begin
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = $urandom_range(1, 8);
                end
                else
                    burst_left = burst_left - 1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: steer %0d speed %0d clamped %0d",
                             result.steer_cmd, result.speed_cmd, result.steer_clamped);
            end
            else if (result !== expected_cmds[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp steer %0d speed %0d clamped %0d, got %0d %0d %0d",
                             expected_cmds[0].steer_cmd, expected_cmds[0].speed_cmd,
                             expected_cmds[0].steer_clamped, result.steer_cmd,
                             result.speed_cmd, result.steer_clamped);
                void'(expected_cmds.pop_front());
            end
            else
                void'(expected_cmds.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_WHEEL_BASE:  m_wheel_base = value;
            CFG_LOOKAHEAD:   m_lookahead = value;
            CFG_SPEED_SCALE: m_scale = value;
            CFG_STEER_LIMIT: m_limit = value[12:0];
            CFG_MAX_SPEED:   m_max = value[7:0];
            CFG_MIN_SPEED:   m_min = value[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [15:0] wb, logic [15:0] la, logic [15:0] sc,
                             logic [15:0] lim, logic [15:0] mx, logic [15:0] mn);
        write_reg(CFG_WHEEL_BASE, wb);
        write_reg(CFG_LOOKAHEAD, la);
        write_reg(CFG_SPEED_SCALE, sc);
        write_reg(CFG_STEER_LIMIT, lim);
        write_reg(CFG_MAX_SPEED, mx);
        write_reg(CFG_MIN_SPEED, mn);
    endtask

    task automatic queue_item(int px, int py, shortint yw, int tx, int ty);
        item_t it;
        it.pos_x = px;
        it.pos_y = py;
        it.yaw = yw;
        it.target_x = tx;
        it.target_y = ty;
        pending_items.push_back(it);
    endtask

    // mostly a nearby lookahead point, some full-range noise
    task automatic queue_random(int n);
        int px;
        int py;
        for (int k = 0; k < n; k++)
        begin
            px = $urandom;
            py = $urandom;
            if ($urandom_range(0, 3) == 0)
                queue_item($urandom, $urandom, shortint'($urandom), $urandom, $urandom);
            else
                queue_item(px, py, shortint'($urandom),
                           px + $signed($urandom_range(0, 40000)) - 20000,
                           py + $signed($urandom_range(0, 40000)) - 20000);
        end
    endtask

    task automatic drain();
        steady_mode = ($urandom_range(0, 3) == 0);
        while (pending_items.size() != 0 || expected_cmds.size() != 0)
            @(posedge clk);
        repeat (LAT_WAIT) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        burst_left = 1;
        gap_left = 0;
        steady_mode = 1'b0;
        m_wheel_base = WHEEL_BASE_RST;
        m_lookahead = LOOKAHEAD_RST;
        m_scale = SPEED_SCALE_RST;
        m_limit = STEER_LIMIT_RST;
        m_max = MAX_SPEED_RST;
        m_min = MIN_SPEED_RST;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: coincident points, extremes, quadrants, straight ahead
        queue_item(0, 0, 0, 0, 0);
        queue_item(100, 200, 16'sh7fff, 100, 200);
        queue_item(32'sh7fffffff, 32'sh7fffffff, -16'sd32768, 32'sh80000000, 32'sh80000000);
        queue_item(32'sh80000000, 32'sh80000000, 16'sh7fff, 32'sh7fffffff, 32'sh7fffffff);
        queue_item(32'sh80000000, 0, 0, 32'sh7fffffff, 0);
        queue_item(0, 32'sh7fffffff, 0, 0, 32'sh80000000);
        queue_item(0, 0, 0, 1000, 0);
        queue_item(0, 0, 0, -1000, 0);
        queue_item(0, 0, 0, 0, 1000);
        queue_item(0, 0, 0, 0, -1000);
        queue_item(0, 0, 16'sd16384, 1000, 1000);
        queue_item(0, 0, -16'sd16384, -1000, 1000);
        queue_item(0, 0, -16'sd32768, 1000, 0);
        queue_item(5000, -3000, 16'sd8192, 5000, 4000);
        queue_item(-1, -1, 16'sh5555, 1, 1);
        queue_item(32'sh55555555, 32'shaaaaaaaa, 16'shaaaa, 32'shaaaaaaaa, 32'sh55555555);
        queue_random(200);
        drain();

        write_all(16'hffff, 16'd1, 16'hffff, 16'h1fff, 16'hff, 16'h00);
        queue_random(180);
        drain();

        // zero limit and zero lookahead
        write_all(16'd1, 16'd0, 16'd0, 16'd0, 16'd200, 16'd200);
        queue_item(0, 0, 0, 0, 0);
        queue_item(0, 0, 16'sd4096, 1000, 0);
        queue_random(150);
        drain();

        // minimum above maximum
        write_all(16'd2500, 16'd3000, 16'd40000, 16'd1, 16'd0, 16'd255);
        queue_random(150);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 8191)),
                      16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)));
            queue_random(140);
            drain();
        end
        write_all(WHEEL_BASE_RST, 16'd500, SPEED_SCALE_RST, 16'd300, 16'd60, 16'd10);
        queue_random(60);
        drain();

        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
